/* sv/otbc_pkg.sv */
// ----------------------------------------------------------------------------
// otbc_pkg
// Shared types and constants for the object table box collision block.
// ----------------------------------------------------------------------------
package otbc_pkg;

    localparam int MAX_OBJECTS = 8;
    localparam int SWEEP_N     = (MAX_OBJECTS < 8) ? MAX_OBJECTS : 8;
    localparam int SLOT_W      = $clog2(MAX_OBJECTS);
    localparam int CNT_W       = $clog2(SWEEP_N);

    localparam int ID_W    = 16;
    localparam int COORD_W = 15;
    localparam int SIZE_W  = 10;
    localparam int BOUND_W = COORD_W + 1;
    localparam int MASK_W  = 8;
    localparam int HALF_PAD_W = BOUND_W - SIZE_W + 1;

    localparam int IN_DATA_W  = 72;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 32;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_DELETE = 2'd1,
        OP_SET    = 2'd2,
        OP_SWEEP  = 2'd3
    } op_t;

    typedef struct packed {
        logic             load;
        logic             emit;
        logic             last;
        logic [CNT_W-1:0] idx;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
        logic is_sweep;
    } ctrl_sts_t;

endpackage

/* sv/otbc_ctrl.sv */
// ----------------------------------------------------------------------------
// otbc_ctrl
// Sequencer: takes one input word, then issues one result per cycle while the output is free.
// ----------------------------------------------------------------------------
module otbc_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  otbc_pkg::ctrl_sts_t  sts,
    output otbc_pkg::ctrl_cmd_t  cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

    state_t                     state_reg;
    state_t                     state_next;
    logic [otbc_pkg::CNT_W-1:0] idx_reg;
    logic [otbc_pkg::CNT_W-1:0] idx_next;
    logic                       idx_end;

    assign in_ready = (state_reg == ST_IDLE);
    assign idx_end  = (idx_reg == otbc_pkg::CNT_W'(otbc_pkg::SWEEP_N - 1));

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd.load   = 1'b0;
        cmd.emit   = 1'b0;
        cmd.last   = !sts.is_sweep || idx_end;
        cmd.idx    = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    idx_next   = '0;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (cmd.last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

/* sv/otbc_datapath.sv */
// ----------------------------------------------------------------------------
// otbc_datapath
// Slot table, id counter, corner test lanes and output register.
// ----------------------------------------------------------------------------
module otbc_datapath
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  otbc_pkg::ctrl_cmd_t               cmd,
    output otbc_pkg::ctrl_sts_t               sts,
    input  logic [otbc_pkg::IN_DATA_W-1:0]    in_data,
    input  logic [otbc_pkg::IN_USER_W-1:0]    in_user,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [otbc_pkg::OUT_DATA_W-1:0]   out_data,
    output logic                              out_last
);

    otbc_pkg::op_t                      op_reg;
    logic [2:0]                         sidx_reg;
    logic [otbc_pkg::ID_W-1:0]          tid_reg;
    logic [otbc_pkg::COORD_W-1:0]       px_reg;
    logic [otbc_pkg::COORD_W-1:0]       py_reg;
    logic [otbc_pkg::SIZE_W-1:0]        w_reg;
    logic [otbc_pkg::SIZE_W-1:0]        h_reg;

    logic [otbc_pkg::ID_W-1:0]          id_reg [otbc_pkg::MAX_OBJECTS];
    logic signed [otbc_pkg::BOUND_W-1:0] xl_reg [otbc_pkg::MAX_OBJECTS];
    logic signed [otbc_pkg::BOUND_W-1:0] xr_reg [otbc_pkg::MAX_OBJECTS];
    logic signed [otbc_pkg::BOUND_W-1:0] yt_reg [otbc_pkg::MAX_OBJECTS];
    logic signed [otbc_pkg::BOUND_W-1:0] yb_reg [otbc_pkg::MAX_OBJECTS];
    logic [otbc_pkg::ID_W-1:0]          next_id_reg;
    logic [otbc_pkg::ID_W-1:0]          next_id_inc;

    logic signed [otbc_pkg::BOUND_W-1:0] px_ext;
    logic signed [otbc_pkg::BOUND_W-1:0] py_ext;
    logic signed [otbc_pkg::BOUND_W-1:0] hw_ext;
    logic signed [otbc_pkg::BOUND_W-1:0] hh_ext;
    logic signed [otbc_pkg::BOUND_W-1:0] xl_new;
    logic signed [otbc_pkg::BOUND_W-1:0] xr_new;
    logic signed [otbc_pkg::BOUND_W-1:0] yt_new;
    logic signed [otbc_pkg::BOUND_W-1:0] yb_new;

    logic                               free_found;
    logic [otbc_pkg::SLOT_W-1:0]        free_slot;
    logic [otbc_pkg::SLOT_W-1:0]        set_slot;
    logic                               set_ok;
    logic [otbc_pkg::SLOT_W-1:0]        sel;
    logic                               sel_occ;
    logic [otbc_pkg::MASK_W-1:0]        hit_mask;
    logic                               do_add;
    logic                               do_set;

    logic [2:0]                         res_slot_reg;
    logic [otbc_pkg::ID_W-1:0]          res_id_reg;
    logic                               res_occ_reg;
    logic [otbc_pkg::MASK_W-1:0]        res_mask_reg;
    logic                               res_full_reg;
    logic                               res_last_reg;
    logic                               out_valid_reg;

    assign sts.out_free = !out_valid_reg || out_ready;
    assign sts.is_sweep = (op_reg == otbc_pkg::OP_SWEEP);

    assign px_ext = {px_reg[otbc_pkg::COORD_W-1], px_reg};
    assign py_ext = {py_reg[otbc_pkg::COORD_W-1], py_reg};
    assign hw_ext = {otbc_pkg::HALF_PAD_W'(0), w_reg[otbc_pkg::SIZE_W-1:1]};
    assign hh_ext = {otbc_pkg::HALF_PAD_W'(0), h_reg[otbc_pkg::SIZE_W-1:1]};
    assign xl_new = px_ext - hw_ext;
    assign xr_new = px_ext + hw_ext;
    assign yt_new = py_ext - hh_ext;
    assign yb_new = py_ext + hh_ext;

    assign next_id_inc = (next_id_reg == '1) ? otbc_pkg::ID_W'(1) : next_id_reg + 1'b1;

    assign set_slot = otbc_pkg::SLOT_W'(sidx_reg);
    assign set_ok   = (int'(sidx_reg) < otbc_pkg::MAX_OBJECTS);
    assign sel      = otbc_pkg::SLOT_W'(cmd.idx);
    assign sel_occ  = (id_reg[sel] != '0);

    assign do_add = cmd.emit && (op_reg == otbc_pkg::OP_ADD) && free_found;
    assign do_set = cmd.emit && (op_reg == otbc_pkg::OP_SET) && set_ok;

    always_comb
    begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int k = otbc_pkg::MAX_OBJECTS - 1; k >= 0; k--)
        begin
            if (id_reg[k] == '0)
            begin
                free_found = 1'b1;
                free_slot  = otbc_pkg::SLOT_W'(k);
            end
        end
    end

    always_comb
    begin
        logic xh;
        logic yh;
        hit_mask = '0;
        for (int j = 0; j < otbc_pkg::SWEEP_N; j++)
        begin
            xh = ((xl_reg[j] >= xl_reg[sel]) && (xl_reg[j] <= xr_reg[sel])) ||
                 ((xr_reg[j] >= xl_reg[sel]) && (xr_reg[j] <= xr_reg[sel]));
            yh = ((yt_reg[j] >= yt_reg[sel]) && (yt_reg[j] <= yb_reg[sel])) ||
                 ((yb_reg[j] >= yt_reg[sel]) && (yb_reg[j] <= yb_reg[sel]));
            hit_mask[j] = sel_occ && (otbc_pkg::SLOT_W'(j) != sel) &&
                          (id_reg[j] != '0) && xh && yh;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= otbc_pkg::op_t'(in_user);
            sidx_reg <= in_data[2:0];
            tid_reg  <= in_data[18:3];
            px_reg   <= in_data[33:19];
            py_reg   <= in_data[48:34];
            w_reg    <= in_data[58:49];
            h_reg    <= in_data[68:59];
        end
        if (do_add)
        begin
            xl_reg[free_slot] <= xl_new;
            xr_reg[free_slot] <= xr_new;
            yt_reg[free_slot] <= yt_new;
            yb_reg[free_slot] <= yb_new;
        end
        else if (do_set)
        begin
            xl_reg[set_slot] <= xl_new;
            xr_reg[set_slot] <= xr_new;
            yt_reg[set_slot] <= yt_new;
            yb_reg[set_slot] <= yb_new;
        end
        if (cmd.emit)
        begin
            res_slot_reg <= '0;
            res_id_reg   <= '0;
            res_occ_reg  <= 1'b0;
            res_mask_reg <= '0;
            res_full_reg <= 1'b0;
            res_last_reg <= cmd.last;
            unique case (op_reg)
                otbc_pkg::OP_ADD:
                begin
                    if (free_found)
                    begin
                        res_slot_reg <= 3'(free_slot);
                        res_id_reg   <= next_id_reg;
                    end
                    else
                    begin
                        res_full_reg <= 1'b1;
                    end
                end
                otbc_pkg::OP_SWEEP:
                begin
                    res_slot_reg <= 3'(cmd.idx);
                    res_id_reg   <= id_reg[sel];
                    res_occ_reg  <= sel_occ;
                    res_mask_reg <= hit_mask;
                end
                otbc_pkg::OP_DELETE, otbc_pkg::OP_SET:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < otbc_pkg::MAX_OBJECTS; k++)
            begin
                id_reg[k] <= '0;
            end
            next_id_reg   <= otbc_pkg::ID_W'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (do_add)
            begin
                id_reg[free_slot] <= next_id_reg;
                next_id_reg       <= next_id_inc;
            end
            if (cmd.emit && (op_reg == otbc_pkg::OP_DELETE))
            begin
                for (int k = 0; k < otbc_pkg::MAX_OBJECTS; k++)
                begin
                    if (id_reg[k] == tid_reg)
                    begin
                        id_reg[k] <= '0;
                    end
                end
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_last  = res_last_reg;
    assign out_data  = {3'b000, res_full_reg, res_mask_reg, res_occ_reg, res_id_reg,
                        res_slot_reg};

endmodule

/* sv/object_table_box_collision.sv */
// ----------------------------------------------------------------------------
// object_table_box_collision
// Object slot table with add, delete, set and axis-aligned box sweep.
//
// Channel   Dir  Signals                     Contents
// s_axis    in   tvalid tready tdata tuser   op in tuser; slot_index..box_height
// m_axis    out  tvalid tready tdata tlast   result_slot..table_full; last
//
// Add, delete and set: the word is taken, then a single result is produced.
// Sweep: the word is taken, then one result per cycle, eight in all;
// eight compare lanes test every slot against the swept slot's box each cycle.
// Reset clears all ids and sets the next id to one.
// A stalled output holds the sequencer; a new word is taken as soon as the
// last result is in the output register.
// ----------------------------------------------------------------------------
module object_table_box_collision
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // slot_index, target_id, pos_x, pos_y, box_width, box_height
    input  logic [otbc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // op
    input  logic [otbc_pkg::IN_USER_W-1:0]   s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // result_slot, result_id, occupied, hit_mask, table_full
    output logic [otbc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                             m_axis_tlast
);

    otbc_pkg::ctrl_cmd_t cmd;
    otbc_pkg::ctrl_sts_t sts;

    otbc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    otbc_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (s_axis_tdata),
        .in_user   (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while previous item in progress");

    a_full_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[28] |-> m_axis_tlast)
        else $error("table full result not marked last");

    a_empty_no_hits: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[19] |-> m_axis_tdata[27:20] == 8'h00)
        else $error("hit mask set for empty slot");
`endif

endmodule
